### sv/stereo_lfo_flanger_macros.svh
// Assertion helpers for the flanger block.
// Both sample on clk and are disabled while rst_n is low.
`ifndef STEREO_LFO_FLANGER_MACROS_SVH
`define STEREO_LFO_FLANGER_MACROS_SVH

// same-cycle implication
`define SLF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/slf_pkg.sv
package slf_pkg;

  localparam int MAX_DELAY = 32768;
  localparam int PTR_W     = $clog2(MAX_DELAY);
  localparam int LEN_W     = PTR_W + 1;
  localparam int CNT_W     = $clog2(PTR_W);

  localparam int COS_DEPTH = 1024;
  localparam int COS_AW    = $clog2(COS_DEPTH);
  localparam int COS_W     = 17;

  localparam int PHASE_W   = 24;
  localparam int SMP_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int DEPTH_W   = 17;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // shared multiplier: a is the wide operand, b the gain-like one
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int M_W       = 32;
  localparam int WOB_LSB   = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WET_DEPTH     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_AMOUNT  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = CFG_IDX_W'(4);

  localparam logic [GAIN_W-1:0]         RST_DELAY_LENGTH  = GAIN_W'(24000);
  localparam logic [GAIN_W-1:0]         RST_FEEDBACK_GAIN = GAIN_W'(16384);
  localparam logic signed [DEPTH_W-1:0] RST_WET_DEPTH     = DEPTH_W'(16384);
  localparam logic [GAIN_W-1:0]         RST_SWEEP_AMOUNT  = GAIN_W'(32768);
  localparam logic [PHASE_W-1:0]        RST_PHASE_STEP    = PHASE_W'(16777);

  localparam logic [GAIN_W-1:0] SWEEP_ONE = GAIN_W'(32768);
  localparam logic [M_W-1:0]    M_BIAS    = M_W'(64'd1 << 30);

  localparam logic [PHASE_W-1:0] RIGHT_PHASE_OFFSET = PHASE_W'((64'd1 << PHASE_W) / 3);

  localparam longint SMP_MAX = (longint'(1) <<< (SMP_W - 1)) - 1;
  localparam longint SMP_MIN = -(longint'(1) <<< (SMP_W - 1));

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DIV [9] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                             64'd132, 64'd182, 64'd240, 64'd306};

  typedef logic signed [COS_W-1:0] cos_word_t;
  typedef cos_word_t cos_rom_t [COS_DEPTH];

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIV  = 11'b000_0000_0010,
    S_OL   = 11'b000_0000_0100,
    S_OR   = 11'b000_0000_1000,
    S_FL   = 11'b000_0001_0000,
    S_FR   = 11'b000_0010_0000,
    S_ML   = 11'b000_0100_0000,
    S_MR   = 11'b000_1000_0000,
    S_WL   = 11'b001_0000_0000,
    S_WR   = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_t;

  // Q30 Taylor series with quarter-wave folding, rounded to Q1.15
  function automatic cos_word_t cos_entry(input int unsigned k);
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] t;
    longint      sum;
    longint      q;
    logic        neg;
    a   = (64'd2 * PI_Q30 * 64'(k)) / COS_DEPTH;
    t   = 64'd1 << 30;
    sum = longint'(1) <<< 30;
    neg = 1'b0;
    if (a > PI_Q30) a = 64'd2 * PI_Q30 - a;
    if (a > PI_Q30 / 2) begin
      a   = PI_Q30 - a;
      neg = 1'b1;
    end
    x2 = (a * a) >> 30;
    for (int n = 0; n < 9; n++) begin
      t = ((t * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 0) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    q = longint'((64'(sum) + 64'd16384) >> 15);
    if (q > 32768) q = 32768;
    return neg ? COS_W'(-q) : COS_W'(q);
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int k = 0; k < COS_DEPTH; k++) rom[k] = cos_entry(k);
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  function automatic logic [COS_AW-1:0] phase_idx(input logic [PHASE_W-1:0] p);
    logic [PHASE_W+COS_AW:0] x;
    x = (PHASE_W+COS_AW+1)'(p) * (PHASE_W+COS_AW+1)'(COS_DEPTH);
    return COS_AW'(x >> PHASE_W);
  endfunction

  function automatic logic [LEN_W-1:0] eff_length(input logic [GAIN_W-1:0] v);
    if (v == '0) return LEN_W'(1);
    if (LEN_W'(v) > LEN_W'(MAX_DELAY)) return LEN_W'(MAX_DELAY);
    return LEN_W'(v);
  endfunction

  // floor(x / 2^16), clamped to the sample range
  function automatic logic signed [SMP_W-1:0] sat_shift(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] s;
    s = x >>> 16;
    if (s > ACC_W'(SMP_MAX)) return SMP_W'(SMP_MAX);
    if (s < ACC_W'(SMP_MIN)) return SMP_W'(SMP_MIN);
    return s[SMP_W-1:0];
  endfunction

endpackage

### sv/stereo_lfo_flanger.sv
// An item steps through S_OL..S_WR, then S_FIN registers out_valid once the output is free;
// in_stall is high meanwhile. If delay_length was lowered to or below the write position,
// the next item first runs a bit-serial remainder over the PTR_W (15) bits of w_r. Both
// channels share one multiplier. Reset (synchronous, rst_n low) clears positions, LFO
// phase and registers to defaults. Delay memories are not swept: a fill count tracks the
// written prefix, so words never written read as zero. Items are accepted right out of reset.
`include "stereo_lfo_flanger_macros.svh"

module stereo_lfo_flanger import slf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SMP_W-1:0] out_left,
  output logic signed [SMP_W-1:0] out_right,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]         len_cfg_r;
  logic [GAIN_W-1:0]         fb_r;
  logic signed [DEPTH_W-1:0] depth_r;
  logic [GAIN_W-1:0]         sweep_r;
  logic [PHASE_W-1:0]        step_r;

  logic [PTR_W-1:0]   w_r, rdl_r, rdr_r, wm_r;
  logic [LEN_W-1:0]   fill_r, len_r, rem_r;
  logic [CNT_W-1:0]   bit_cnt_r;
  logic [PHASE_W-1:0] phase_r;
  logic [COS_AW-1:0]  idx_l_r, idx_r_r;
  cos_word_t          cos_q_r;
  logic               vl_r, vr_r;

  logic signed [SMP_W-1:0]  in_r, dl_r, dr_r, out_l_r, out_r_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [M_W-1:0]           m_l_r, m_r_r;

  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_left_r, out_right_r;

  logic signed [SMP_W-1:0] mem_l [MAX_DELAY];
  logic signed [SMP_W-1:0] mem_r [MAX_DELAY];

  logic                      accept, out_free, fin_go, wrap_needed, div_last;
  logic [LEN_W-1:0]          len_eff, shifted, rem_nxt;
  logic [GAIN_W-1:0]         sweep_eff;
  logic [PTR_W-1:0]          lenm1, wob, rd_new, wm_inc;
  logic [LEN_W:0]            rd_sum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SMP_W-1:0]   sat_q;
  logic signed [SMP_W-1:0]   dl_eff, dr_eff;
  logic [COS_AW-1:0]         cos_addr;
  logic signed [PROD_W-1:0]  m_diff;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_go    = (state_r == S_FIN) && out_free;
  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  assign len_eff     = eff_length(len_cfg_r);
  assign wrap_needed = ({1'b0, w_r} >= len_eff);
  assign sweep_eff   = (sweep_r > SWEEP_ONE) ? SWEEP_ONE : sweep_r;
  assign lenm1       = PTR_W'(len_r - LEN_W'(1));

  // restoring remainder, one bit of the write position per cycle
  assign shifted  = {rem_r[PTR_W-1:0], w_r[bit_cnt_r]};
  assign rem_nxt  = (shifted >= len_r) ? shifted - len_r : shifted;
  assign div_last = (bit_cnt_r == '0);

  assign dl_eff = vl_r ? dl_r : '0;
  assign dr_eff = vr_r ? dr_r : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_OL: begin
        mul_a = MUL_A_W'(dl_eff);
        mul_b = MUL_B_W'(depth_r);
      end
      S_OR: begin
        mul_a = MUL_A_W'(dr_eff);
        mul_b = MUL_B_W'(depth_r);
      end
      S_FL: begin
        mul_a = MUL_A_W'(out_l_r);
        mul_b = $signed({2'b00, fb_r});
      end
      S_FR: begin
        mul_a = MUL_A_W'(out_r_r);
        mul_b = $signed({2'b00, fb_r});
      end
      S_ML, S_MR: begin
        mul_a = MUL_A_W'(cos_q_r);
        mul_b = $signed({2'b00, sweep_eff});
      end
      S_WL: begin
        mul_a = $signed({1'b0, m_l_r});
        mul_b = $signed({3'b000, lenm1});
      end
      S_WR: begin
        mul_a = $signed({1'b0, m_r_r});
        mul_b = $signed({3'b000, lenm1});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign acc    = (ACC_W'(in_r) <<< 15) + ACC_W'(prod_r);
  assign sat_q  = sat_shift(acc);
  assign m_diff = $signed({{(PROD_W-M_W){1'b0}}, M_BIAS}) - prod_r;

  // wm + 1 <= len and wob < len, so one subtract finishes the wrap
  assign wob    = prod_r[WOB_LSB+PTR_W-1:WOB_LSB];
  assign rd_sum = (LEN_W+1)'(wm_r) + (LEN_W+1)'(1) + (LEN_W+1)'(wob);
  assign rd_new = (rd_sum >= {1'b0, len_r}) ? PTR_W'(rd_sum - {1'b0, len_r}) : PTR_W'(rd_sum);
  assign wm_inc = ((LEN_W'(wm_r) + LEN_W'(1)) == len_r) ? '0 : wm_r + PTR_W'(1);

  assign cos_addr = (state_r == S_FR) ? idx_l_r : idx_r_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = wrap_needed ? S_DIV : S_OL;
      S_DIV:   if (div_last) state_nxt = S_OL;
      S_OL:    state_nxt = S_OR;
      S_OR:    state_nxt = S_FL;
      S_FL:    state_nxt = S_FR;
      S_FR:    state_nxt = S_ML;
      S_ML:    state_nxt = S_MR;
      S_MR:    state_nxt = S_WL;
      S_WL:    state_nxt = S_WR;
      S_WR:    state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      w_r         <= '0;
      rdl_r       <= '0;
      rdr_r       <= '0;
      fill_r      <= '0;
      phase_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == S_WR) rdl_r <= rd_new;
      if (fin_go) begin
        rdr_r       <= rd_new;
        w_r         <= wm_inc;
        phase_r     <= phase_r + step_r;
        if ({1'b0, w_r} >= fill_r) fill_r <= LEN_W'(w_r) + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= RST_DELAY_LENGTH;
      fb_r      <= RST_FEEDBACK_GAIN;
      depth_r   <= RST_WET_DEPTH;
      sweep_r   <= RST_SWEEP_AMOUNT;
      step_r    <= RST_PHASE_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY_LENGTH:  len_cfg_r <= cfg_wdata[GAIN_W-1:0];
        CFG_FEEDBACK_GAIN: fb_r      <= cfg_wdata[GAIN_W-1:0];
        CFG_WET_DEPTH:     depth_r   <= $signed(cfg_wdata[DEPTH_W-1:0]);
        CFG_SWEEP_AMOUNT:  sweep_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_PHASE_STEP:    step_r    <= cfg_wdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r      <= in_sample;
      len_r     <= len_eff;
      wm_r      <= w_r;
      rem_r     <= '0;
      bit_cnt_r <= CNT_W'(PTR_W - 1);
      vl_r      <= ({1'b0, rdl_r} < fill_r);
      vr_r      <= ({1'b0, rdr_r} < fill_r);
      idx_l_r   <= phase_idx(phase_r);
      idx_r_r   <= phase_idx(phase_r + RIGHT_PHASE_OFFSET);
    end
    if (state_r == S_DIV) begin
      rem_r     <= rem_nxt;
      bit_cnt_r <= bit_cnt_r - CNT_W'(1);
      if (div_last) wm_r <= rem_nxt[PTR_W-1:0];
    end
    // right wobble product must survive an output stall in S_FIN
    if (state_r != S_FIN) prod_r <= mul_p;
    if (state_r == S_OR) out_l_r <= sat_q;
    if (state_r == S_FL) out_r_r <= sat_q;
    if (state_r == S_MR) m_l_r <= m_diff[M_W-1:0];
    if (state_r == S_WL) m_r_r <= m_diff[M_W-1:0];
    if (state_r == S_FR || state_r == S_ML) cos_q_r <= COS_ROM[cos_addr];
    if (fin_go) begin
      out_left_r  <= out_l_r;
      out_right_r <= out_r_r;
    end
  end

  // delay lines: reads at accept, writes later in the same item, so reads see old words
  always_ff @(posedge clk) begin
    if (state_r == S_FR) mem_l[w_r] <= sat_q;
    if (accept) dl_r <= mem_l[rdl_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ML) mem_r[w_r] <= sat_q;
    if (accept) dr_r <= mem_r[rdr_r];
  end

  `SLF_ASSERT(a_fill_prefix, 1'b1, {1'b0, w_r} <= fill_r, "write position past written prefix")
  `SLF_ASSERT(a_rem_range, state_r == S_DIV, rem_r < len_r, "remainder not below length")
  `SLF_ASSERT(a_rdl_range, state_r == S_FIN, {1'b0, rdl_r} < len_r, "left read position out of range")
  `SLF_ASSERT_NEXT(a_out_load, fin_go, out_valid_r && state_r == S_IDLE, "result not loaded")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slf_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int STEADY_ITEMS  = 150;

  // index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);

  localparam logic signed [SMP_W-1:0] PEAK_POS = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] PEAK_NEG = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic signed [SMP_W-1:0] EDGE_SAMPLES [6] =
    '{PEAK_POS, PEAK_NEG, 24'sd0, -24'sd1, 24'sd1, 24'sh5A5A5A};
  localparam logic [GAIN_W-1:0] LEN_EDGES [7] =
    '{16'd0, 16'd1, 16'd2, 16'd32767, 16'd32768, 16'd32769, 16'd65535};

  typedef struct {
    logic signed [SMP_W-1:0] left_smp;
    logic signed [SMP_W-1:0] right_smp;
  } stereo_pair_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SMP_W-1:0] out_left;
  logic signed [SMP_W-1:0] out_right;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  // predictor state
  logic signed [SMP_W-1:0]   left_line [MAX_DELAY];
  logic signed [SMP_W-1:0]   right_line [MAX_DELAY];
  int                        cos_tab [COS_DEPTH];
  int unsigned               write_ptr = 0;
  int unsigned               left_tap = 0;
  int unsigned               right_tap = 0;
  logic [PHASE_W-1:0]        lfo_acc = '0;
  logic [GAIN_W-1:0]         line_len = RST_DELAY_LENGTH;
  logic [GAIN_W-1:0]         fb_gain = RST_FEEDBACK_GAIN;
  logic signed [DEPTH_W-1:0] wet_gain = RST_WET_DEPTH;
  logic [GAIN_W-1:0]         sweep_gain = RST_SWEEP_AMOUNT;
  logic [PHASE_W-1:0]        lfo_step = RST_PHASE_STEP;

  stereo_pair_t due_pairs [$];
  int           err_count = 0;
  int           result_count = 0;
  int           cycle_count = 0;
  int           idle_pct = 0;
  int           stall_hold = 0;

  stereo_lfo_flanger u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_right (out_right),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cosine table (Q30 Taylor series, quarter-wave folded) and empty delay lines
  initial begin : predictor_init
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    bit              neg;
    for (int k = 0; k < COS_DEPTH; k++) begin
      ang  = (64'd2 * PI_Q30 * 64'(k)) / COS_DEPTH;
      term = 64'd1 << 30;
      acc  = longint'(1) <<< 30;
      neg  = 1'b0;
      if (ang > PI_Q30) ang = 64'd2 * PI_Q30 - ang;
      if (ang > PI_Q30 / 2) begin
        ang = PI_Q30 - ang;
        neg = 1'b1;
      end
      sq = (ang * ang) >> 30;
      for (int n = 1; n <= 9; n++) begin
        term = ((term * sq) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 16384) >>> 15;
      if (acc > 32768) acc = 32768;
      cos_tab[k] = neg ? -int'(acc) : int'(acc);
    end
    for (int i = 0; i < MAX_DELAY; i++) begin
      left_line[i]  = '0;
      right_line[i] = '0;
    end
  end

  function automatic logic signed [SMP_W-1:0] clip24(input longint v);
    if (v > PEAK_POS) return PEAK_POS;
    if (v < PEAK_NEG) return PEAK_NEG;
    return SMP_W'(v);
  endfunction

  // One channel of the flanger: output from the old tap word, feedback written
  // at the shared write pointer, then the tap moves to its LFO-swept position.
  function automatic logic signed [SMP_W-1:0] tap_channel(input bit is_right,
      input logic [PHASE_W-1:0] ph, input longint x, input int unsigned len);
    int unsigned             rp;
    int unsigned             ci;
    longint                  dly;
    longint                  sw;
    longint                  m;
    longint                  wob;
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] fed;
    rp  = is_right ? right_tap : left_tap;
    dly = is_right ? right_line[rp] : left_line[rp];
    y   = clip24((x * 32768 + longint'(wet_gain) * dly) >>> 16);
    fed = clip24((x * 32768 + longint'(fb_gain) * longint'(y)) >>> 16);
    if (is_right) right_line[write_ptr] = fed;
    else left_line[write_ptr] = fed;
    sw  = (sweep_gain > SWEEP_ONE) ? longint'(SWEEP_ONE) : longint'(sweep_gain);
    ci  = int'((64'(ph) * COS_DEPTH) >> PHASE_W);
    m   = (longint'(1) <<< 30) - sw * longint'(cos_tab[ci]);
    wob = (longint'(len - 1) * m) >>> 31;
    if (is_right) right_tap = int'((longint'(write_ptr) + 1 + wob) % len);
    else left_tap = int'((longint'(write_ptr) + 1 + wob) % len);
    return y;
  endfunction

  task automatic report_error(input string msg);
    if (err_count < 100) $display("ERROR: %s", msg);
    err_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    case (idx)
      CFG_DELAY_LENGTH:  line_len = data[GAIN_W-1:0];
      CFG_FEEDBACK_GAIN: fb_gain = data[GAIN_W-1:0];
      CFG_WET_DEPTH:     wet_gain = data[DEPTH_W-1:0];
      CFG_SWEEP_AMOUNT:  sweep_gain = data[GAIN_W-1:0];
      CFG_PHASE_STEP:    lfo_step = data[PHASE_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits above each register's width carry junk
  task automatic load_config(input logic [GAIN_W-1:0] len, input logic [GAIN_W-1:0] fb,
      input logic signed [DEPTH_W-1:0] depth, input logic [GAIN_W-1:0] sweep,
      input logic [PHASE_W-1:0] step);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    write_reg(CFG_SPARE, junk);
    write_reg(CFG_DELAY_LENGTH, {junk[CFG_W-1:GAIN_W], len});
    write_reg(CFG_FEEDBACK_GAIN, {junk[CFG_W-1:GAIN_W], fb});
    write_reg(CFG_WET_DEPTH, {junk[CFG_W-1:DEPTH_W], depth});
    write_reg(CFG_SWEEP_AMOUNT, {junk[CFG_W-1:GAIN_W], sweep});
    write_reg(CFG_PHASE_STEP, step);
    cfg_we <= 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_sample(input logic signed [SMP_W-1:0] smp);
    stereo_pair_t pr;
    int unsigned  len;
    if ($urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    len = (line_len == 0) ? 1 : ((line_len > MAX_DELAY) ? MAX_DELAY : line_len);
    pr.left_smp  = tap_channel(1'b0, lfo_acc, longint'(smp), len);
    pr.right_smp = tap_channel(1'b1, lfo_acc + RIGHT_PHASE_OFFSET, longint'(smp), len);
    write_ptr = (write_ptr + 1) % len;
    lfo_acc   = lfo_acc + lfo_step;
    due_pairs.push_back(pr);
    @(negedge clk);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (due_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return PEAK_POS;
      1: return PEAK_NEG;
      2: return SMP_W'(int'($urandom_range(0, 511)) - 256);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // mostly short lines so feedback and wrap-around get exercised
  task automatic random_config();
    logic [GAIN_W-1:0]         len;
    logic [GAIN_W-1:0]         fb;
    logic signed [DEPTH_W-1:0] depth;
    logic [GAIN_W-1:0]         sweep;
    logic [PHASE_W-1:0]        step;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: len = GAIN_W'($urandom_range(1, 48));
      6, 7: len = GAIN_W'($urandom_range(49, 3000));
      8: len = GAIN_W'($urandom);
      default: len = LEN_EDGES[$urandom_range(0, 6)];
    endcase
    fb = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 32768));
    depth = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom)
                                        : DEPTH_W'(int'($urandom_range(0, 65536)) - 32768);
    sweep = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom)
                                        : GAIN_W'($urandom_range(0, 32768));
    case ($urandom_range(0, 5))
      0: step = '0;
      1: step = PHASE_W'($urandom);
      default: step = PHASE_W'($urandom_range(1, 1 << 20));
    endcase
    load_config(len, fb, depth, sweep, step);
  endtask

  task automatic test_defaults();
    idle_pct = 20;
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
    finish_phase();
  endtask

  // length 0 acts as 1, so every read hits the word being written
  task automatic test_saturation();
    load_config(16'd0, 16'hFFFF, 17'sh0FFFF, 16'hFFFF, 24'hFFFFFF);
    repeat (4) send_sample(PEAK_POS);
    repeat (3) send_sample(PEAK_NEG);
    finish_phase();
  endtask

  task automatic test_inverted_depth();
    load_config(16'd2, SWEEP_ONE, 17'sh10000, 16'd0, 24'd0);
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
    finish_phase();
  endtask

  task automatic test_longest_line();
    load_config(16'hFFFF, 16'd0, 17'sd32768, SWEEP_ONE, 24'd1);
    repeat (5) send_sample(random_sample());
    finish_phase();
  endtask

  task automatic test_random_settings();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_config();
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 25;
        default: idle_pct = 50;
      endcase
      n = $urandom_range(15, 90);
      repeat (n) send_sample(random_sample());
      sent += n;
      finish_phase();
    end
  endtask

  task automatic test_steady_stream();
    idle_pct = 0;
    random_config();
    repeat (STEADY_ITEMS) send_sample(random_sample());
    finish_phase();
  endtask

  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
      out_stall <= 1'b1;
    end else if (rst_n && $urandom_range(1, 100) <= idle_pct) begin
      stall_hold = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    stereo_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_pairs.size() == 0) begin
        report_error($sformatf("result %0d with nothing pending: L=%0d R=%0d",
                               result_count, out_left, out_right));
      end else begin
        want = due_pairs.pop_front();
        if (out_left !== want.left_smp)
          report_error($sformatf("result %0d out_left got %0d want %0d",
                                 result_count, out_left, want.left_smp));
        if (out_right !== want.right_smp)
          report_error($sformatf("result %0d out_right got %0d want %0d",
                                 result_count, out_right, want.right_smp));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_saturation();
    test_inverted_depth();
    test_longest_line();
    test_random_settings();
    test_steady_stream();
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
